// ===== design/tcgp_pkg.sv =====
package tcgp_pkg;

  // Request codes
  localparam logic REQ_TEXT   = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  // Character codes the placer reacts to
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHAR_C_UPPER = 8'h43;
  localparam logic [7:0] CHAR_C_LOWER = 8'h63;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;

  // Pixel offset of the grid origin
  localparam logic [9:0] PIX_OFFSET_X = 10'd16;
  localparam logic [7:0] PIX_OFFSET_Y = 8'd16;

  // Escape sequence phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TILDE = 3'd1,
    PH_D1    = 3'd2,
    PH_D2    = 3'd3,
    PH_D3    = 3'd4
  } phase_e;

  // Input word
  typedef struct packed {
    logic        req_type;
    logic [7:0]  text_byte;
    logic [6:0]  set_column;
    logic [4:0]  set_row;
    logic [28:0] set_color;
  } req_t;

  // Result word
  typedef struct packed {
    logic [9:0]  draw_x;
    logic [7:0]  draw_y;
    logic [7:0]  glyph;
    logic [28:0] draw_color;
  } rsp_t;

endpackage

// ===== design/text_cursor_glyph_placer_top.sv =====
// Text cursor glyph placer.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per
// cycle while in_stall_o is low: either a text byte or a set-cursor request
// that loads column, row and color. Text bytes move a cursor over the character
// grid and run the "~c"/"~C" color escape. Only outside an escape and on a
// grid row does a byte other than NUL, NL, space or "~" make one draw word,
// with pixel position, glyph and color, on out_valid_o/out_stall_i/out_data_o.
//
// Throughput is one input word per cycle while in_stall_o is low: the word is
// held in an input register, and the whole cursor update is done from that
// register once the output register is free, writing the output register.
//
// When the receiver stalls, the output register holds its word and the input
// stage keeps accepting until its own register is full; in_stall_o then rises
// only while out_valid_o and out_stall_i are both high.
//
// Reset clears the cursor, color, escape phase, digits and both valid bits.
module text_cursor_glyph_placer_top #(
  parameter int GRID_COLUMNS = 76,
  parameter int GRID_ROWS    = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcgp_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcgp_pkg::rsp_t out_data_o
);
  import tcgp_pkg::*;

  localparam logic [6:0] ColLimit = 7'(GRID_COLUMNS);
  localparam logic [4:0] RowLimit = 5'(GRID_ROWS);

  // Input stage
  logic   s1_valid_q;
  req_t   s1_data_q;

  // Cursor state
  logic [6:0]  col_q, col_d;
  logic [4:0]  row_q, row_d;
  logic [28:0] color_q, color_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  dig1_q, dig1_d;
  logic [7:0]  dig2_q, dig2_d;

  // Output stage
  logic  out_valid_q;
  rsp_t  out_data_q;
  rsp_t  draw_word;

  logic       out_free;
  logic       fire;
  logic       draw;
  logic       advance;
  logic       wrap;
  logic [7:0] col_inc;
  logic [7:0] byte_digit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign col_inc    = {1'b0, col_q} + 8'd1;
  assign byte_digit = s1_data_q.text_byte - CHAR_DIGIT0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Next cursor state
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    color_d = color_q;
    phase_d = phase_q;
    dig1_d  = dig1_q;
    dig2_d  = dig2_q;
    draw    = 1'b0;
    advance = 1'b0;
    wrap    = 1'b0;
    if (fire) begin
      if (s1_data_q.req_type == REQ_CURSOR) begin
        col_d   = s1_data_q.set_column;
        row_d   = s1_data_q.set_row;
        color_d = s1_data_q.set_color;
      end else if (s1_data_q.text_byte == CHAR_NUL) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_TILDE: begin
            if (s1_data_q.text_byte == CHAR_C_LOWER ||
                s1_data_q.text_byte == CHAR_C_UPPER) begin
              phase_d = PH_D1;
            end else begin
              phase_d = PH_IDLE;
              wrap    = 1'b1;
            end
          end
          PH_D1: begin
            dig1_d  = byte_digit;
            phase_d = PH_D2;
          end
          PH_D2: begin
            dig2_d  = byte_digit;
            phase_d = PH_D3;
          end
          PH_D3: begin
            color_d = {byte_digit, dig2_q, dig1_q, 5'b00000};
            phase_d = PH_IDLE;
            wrap    = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
            if (row_q < RowLimit) begin
              priority if (s1_data_q.text_byte == CHAR_SPACE) begin
                advance = 1'b1;
              end else if (s1_data_q.text_byte == CHAR_NL) begin
                col_d = '0;
                row_d = row_q + 5'd1;
              end else if (s1_data_q.text_byte == CHAR_TILDE) begin
                phase_d = PH_TILDE;
              end else begin
                draw    = 1'b1;
                advance = 1'b1;
              end
            end
          end
        endcase
      end

      // Column step and end-of-row wrap
      if (advance) begin
        if (col_inc >= {1'b0, ColLimit}) begin
          col_d = '0;
          row_d = row_q + 5'd1;
        end else begin
          col_d = col_inc[6:0];
        end
      end else if (wrap && col_q >= ColLimit) begin
        col_d = '0;
        row_d = row_q + 5'd1;
      end
    end
  end

  // Draw word from the cursor before the step
  always_comb begin
    draw_word.draw_x     = {col_q, 3'b000} + PIX_OFFSET_X;
    draw_word.draw_y     = {row_q, 3'b000} + PIX_OFFSET_Y;
    draw_word.glyph      = s1_data_q.text_byte;
    draw_word.draw_color = color_q;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      color_q <= '0;
      phase_q <= PH_IDLE;
      dig1_q  <= '0;
      dig2_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      color_q <= color_d;
      phase_q <= phase_d;
      dig1_q  <= dig1_d;
      dig2_q  <= dig2_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= draw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      out_data_q <= draw_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/tcgp_checker.sv =====
module tcgp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tcgp_pkg::rsp_t out_data_o
);
  import tcgp_pkg::*;

  // Stalled draw word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("draw word changed while stalled");

  // Input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Positions sit on the eight pixel cell grid
  a_cell_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.draw_x[2:0] == 3'b000 &&
                    out_data_o.draw_y[2:0] == 3'b000)
    else $error("draw position off cell grid");

  // NUL, newline, space and tilde never reach the drawer
  a_glyph_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.glyph != CHAR_NUL && out_data_o.glyph != CHAR_NL &&
                    out_data_o.glyph != CHAR_SPACE && out_data_o.glyph != CHAR_TILDE)
    else $error("control byte drawn as glyph");

endmodule

bind text_cursor_glyph_placer_top tcgp_checker u_tcgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
